[rtl/mitchell_downscale_2x_macros.svh]
// Assertion macros shared by the checker of the Mitchell downscaler.
`ifndef MITCHELL_DOWNSCALE_2X_MACROS_SVH
`define MITCHELL_DOWNSCALE_2X_MACROS_SVH

// Implication checked in the next cycle, ignored while reset is high.
`define MDS_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("downscaler check failed");

// Implication checked in the next cycle, also across reset.
`define MDS_ASSERT_NEXT_ALWAYS(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("downscaler check failed");

`endif

[rtl/mds_pkg.sv]
// Shared constants and types of the Mitchell-Netravali 2x downscaler.
`timescale 1ns / 1ps
package mds_pkg;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int DIM_BITS       = 13;
  localparam int NORM_2D        = 82944;
  localparam int HALF_NORM_2D   = 41472;
  localparam int TAP_BITS       = 9;

  // The normalizer is 1024 times 81: a shift, then a division by 81.
  localparam int NORM_SHIFT     = 10;
  localparam int NORM_ODD       = NORM_2D >> NORM_SHIFT;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BORDER = 2'd2;

  localparam logic signed [TAP_BITS-1:0] TAPS [4] = '{-9'sd10, 9'sd154, 9'sd154, -9'sd10};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_VERT = 6'b000010,
    S_HORZ = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;
endpackage

[rtl/mitchell_downscale_2x.sv]
// Top level of the Mitchell-Netravali (B = C = 1/3) 2x image downscaler.
`timescale 1ns / 1ps
// Usage: source pixels enter in raster order on the s_ stream, one per beat.
// Each output pixel (i,j) is the separable 4x4 filter of source rows and
// columns 2i-1..2i+2 with taps -10,154,154,-10 over 288, rounded to nearest
// with ties up and saturated; it leaves on the m_ stream, with tlast set on
// the last output of the frame. The cfg channel writes image_width (index 0),
// image_height (index 1) and border_mode (index 2); a dimension write
// restarts the frame. Configure only while the block is idle.
// Processing: the block works on one pixel at a time. A pixel that yields no
// output is accepted, then goes through the line store read-modify-write; a
// pixel that completes a window also goes through the vertical and
// horizontal filter steps, the scaling step and a multiply by the reciprocal
// of the normalizer; a sum that clips to zero or full scale skips the
// multiply. The output beat is offered once the done step loads the output
// register.
// Reset: clears counters, column sums, border and output valid; a clearing
// pass then zeroes all MAX_WIDTH line store entries, one per cycle, with
// s_tready held low. Configuration writes are taken always.
// Stall: a result waits in the output register while the block takes the
// next pixel; its next result, and the input, wait until the register frees.
module mitchell_downscale_2x #(
  parameter int MAX_WIDTH  = mds_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = mds_pkg::PIXEL_BITS_DEF,
  parameter int DATA_BITS  = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [DATA_BITS-1:0]          s_tdata,   // [PIXEL_BITS-1:0] pixel_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [DATA_BITS-1:0]          m_tdata,   // [PIXEL_BITS-1:0] pixel_out
  output logic                          m_tlast,   // frame_end
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [mds_pkg::DIM_BITS-1:0]  cfg_data
);
  localparam int CW  = $clog2(MAX_WIDTH);   // column index bits
  localparam int WW  = CW + 1;              // clamped width bits
  localparam int CS  = CW + 3;              // signed column arithmetic
  localparam int RB  = 12;                  // row index bits
  localparam int RS  = 15;                  // signed row arithmetic
  localparam int VW  = PIXEL_BITS + 10;     // vertical sum
  localparam int HW  = PIXEL_BITS + 21;     // horizontal sum
  localparam int XB  = PIXEL_BITS + 7;      // shifted sum below saturation
  localparam int SH  = XB + 7;              // reciprocal shift
  localparam int MB  = SH - 6;              // reciprocal bits
  localparam longint SAT_LIM = longint'(mds_pkg::NORM_2D) <<< PIXEL_BITS;
  // Rounded-up reciprocal of 81; its error times any shifted sum stays
  // below one quotient step, so the product gives the exact floor.
  localparam longint RECIP = ((longint'(1) <<< SH) + longint'(mds_pkg::NORM_ODD) - 1) /
                             longint'(mds_pkg::NORM_ODD);

  mds_pkg::state_t state;

  logic [mds_pkg::DIM_BITS-1:0] width_reg, height_reg;
  logic                         border;
  logic [WW-1:0]                w;
  logic [mds_pkg::DIM_BITS-1:0] h;

  logic [CW-1:0] column_count, c_cur;
  logic [RB-1:0] row_count, r_cur;
  logic [PIXEL_BITS-1:0] pix;

  // Line store: one entry per column holds the three previous rows.
  logic [3*PIXEL_BITS-1:0] mem [MAX_WIDTH];
  logic [3*PIXEL_BITS-1:0] mem_rd, mem_wdata;
  logic [CW-1:0]           mem_waddr;
  logic                    mem_we, mem_re;
  logic                    clearing;
  logic [CW-1:0]           clear_addr;

  logic signed [VW-1:0] column_sums [3];
  logic signed [VW-1:0] v_reg, v_next;
  logic signed [HW-1:0] acc, acc_next;
  logic                 last_reg;
  logic                 row_emit, col_emit;

  logic [XB-1:0]         xq;
  logic [XB+MB-1:0]      prod;
  logic [PIXEL_BITS-1:0] quot;

  logic s_accept;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == mds_pkg::S_IDLE) && !clearing;
  assign s_accept  = s_tvalid && s_tready;
  assign out_load  = (state == mds_pkg::S_DONE) && (!m_tvalid || m_tready);

  // Dimension clamping.
  always_comb begin
    int wi;
    wi = int'(width_reg);
    if (wi < 2) wi = 2;
    if (wi > MAX_WIDTH) wi = MAX_WIDTH;
    w = WW'(wi);
    if (height_reg < 13'd2) h = 13'd2;
    else if (height_reg > 13'(mds_pkg::HEIGHT_LIMIT)) h = 13'(mds_pkg::HEIGHT_LIMIT);
    else h = height_reg;
  end

  assign row_emit = (r_cur >= RB'(2) && !r_cur[0]) ||
                    (!h[0] && ({1'b0, r_cur} == h - 13'd1));
  assign col_emit = (c_cur >= CW'(2) && !c_cur[0]) ||
                    (!w[0] && ({1'b0, c_cur} == w - WW'(1)));

  // Vertical filter over the four window rows, with border handling.
  always_comb begin
    logic signed [RS-1:0] rbase, rrow, d;
    logic                 oob;
    logic [PIXEL_BITS-1:0] val;
    logic signed [VW-1:0] sum;
    rbase = $signed({3'b000, r_cur}) - (r_cur[0] ? 15'sd2 : 15'sd3);
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      rrow = rbase + RS'(k);
      oob  = (rrow < 0) || (rrow >= $signed({2'b00, h}));
      if (rrow < 0) rrow = '0;
      else if (oob) rrow = $signed({2'b00, h}) - 15'sd1;
      d = $signed({3'b000, r_cur}) - rrow;
      if (d == 15'sd0) val = pix;
      else if (d == 15'sd1) val = mem_rd[PIXEL_BITS-1:0];
      else if (d == 15'sd2) val = mem_rd[2*PIXEL_BITS-1:PIXEL_BITS];
      else if (d == 15'sd3) val = mem_rd[3*PIXEL_BITS-1:2*PIXEL_BITS];
      else val = '0;
      if (!(oob && !border))
        sum = sum + VW'(mds_pkg::TAPS[k] * $signed({1'b0, val}));
    end
    v_next = sum;
  end

  // Horizontal filter over the current and three stored vertical sums.
  always_comb begin
    logic signed [CS-1:0] cbase, ccol, d;
    logic                 oob;
    logic signed [VW-1:0] cv;
    logic signed [HW-1:0] sum;
    cbase = $signed({3'b000, c_cur}) - (c_cur[0] ? CS'(2) : CS'(3));
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      ccol = cbase + CS'(k);
      oob  = (ccol < 0) || (ccol >= $signed({2'b00, w}));
      if (ccol < 0) ccol = '0;
      else if (oob) ccol = $signed({2'b00, w}) - CS'(1);
      d = $signed({3'b000, c_cur}) - ccol;
      if (d == CS'(0)) cv = v_reg;
      else if (d == CS'(1)) cv = column_sums[0];
      else if (d == CS'(2)) cv = column_sums[1];
      else if (d == CS'(3)) cv = column_sums[2];
      else cv = '0;
      if (!(oob && !border))
        sum = sum + HW'(mds_pkg::TAPS[k] * cv);
    end
    acc_next = sum + HW'(mds_pkg::HALF_NORM_2D);
  end

  // Division by 81 of the shifted sum, as a multiply by the reciprocal.
  assign prod = {{MB{1'b0}}, xq} * {{XB{1'b0}}, MB'(RECIP)};

  // Line store port control.
  assign mem_re    = s_accept;
  assign mem_we    = clearing || (state == mds_pkg::S_VERT);
  assign mem_waddr = clearing ? clear_addr : c_cur;
  assign mem_wdata = clearing ? '0 : {mem_rd[2*PIXEL_BITS-1:0], pix};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rd <= mem[column_count];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mds_pkg::S_IDLE;
      width_reg    <= 13'd640;
      height_reg   <= 13'd480;
      border       <= 1'b0;
      row_count    <= '0;
      column_count <= '0;
      column_sums  <= '{default: '0};
      clearing     <= 1'b1;
      clear_addr   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + CW'(1);
        if (clear_addr == CW'(MAX_WIDTH - 1)) clearing <= 1'b0;
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          mds_pkg::REG_WIDTH: begin
            width_reg    <= cfg_data;
            row_count    <= '0;
            column_count <= '0;
            column_sums  <= '{default: '0};
          end
          mds_pkg::REG_HEIGHT: begin
            height_reg   <= cfg_data;
            row_count    <= '0;
            column_count <= '0;
            column_sums  <= '{default: '0};
          end
          mds_pkg::REG_BORDER: border <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        mds_pkg::S_IDLE: begin
          if (s_accept) begin
            pix   <= s_tdata[PIXEL_BITS-1:0];
            r_cur <= row_count;
            c_cur <= column_count;
            if ({1'b0, column_count} + WW'(1) >= w) begin
              column_count <= '0;
              row_count <= ({1'b0, row_count} + 13'd1 >= h) ? '0 : row_count + RB'(1);
            end else begin
              column_count <= column_count + CW'(1);
            end
            state <= mds_pkg::S_VERT;
          end
        end
        mds_pkg::S_VERT: begin
          v_reg    <= v_next;
          last_reg <= ({1'b0, r_cur} == h - 13'd1) && ({1'b0, c_cur} == w - WW'(1));
          if (row_emit && col_emit) begin
            state <= mds_pkg::S_HORZ;
          end else begin
            if (row_emit) column_sums <= '{v_next, column_sums[0], column_sums[1]};
            state <= mds_pkg::S_IDLE;
          end
        end
        mds_pkg::S_HORZ: begin
          acc         <= acc_next;
          column_sums <= '{v_reg, column_sums[0], column_sums[1]};
          state       <= mds_pkg::S_PREP;
        end
        mds_pkg::S_PREP: begin
          // Negative sums floor to zero and large ones saturate at once.
          if (acc[HW-1]) begin
            quot  <= '0;
            state <= mds_pkg::S_DONE;
          end else if (acc >= HW'(SAT_LIM)) begin
            quot  <= '1;
            state <= mds_pkg::S_DONE;
          end else begin
            xq    <= acc[mds_pkg::NORM_SHIFT +: XB];
            state <= mds_pkg::S_DIV;
          end
        end
        mds_pkg::S_DIV: begin
          quot  <= prod[SH +: PIXEL_BITS];
          state <= mds_pkg::S_DONE;
        end
        mds_pkg::S_DONE: begin
          if (out_load) begin
            m_tdata <= DATA_BITS'(quot);
            m_tlast <= last_reg;
            state   <= mds_pkg::S_IDLE;
          end
        end
        default: state <= mds_pkg::S_IDLE;
      endcase
    end
  end
endmodule

[rtl/mds_checker.sv]
// Port-level checker for the Mitchell downscaler, with its bind.
`timescale 1ns / 1ps
`include "mitchell_downscale_2x_macros.svh"
module mds_checker #(
  parameter int DATA_BITS = mds_pkg::PIXEL_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [DATA_BITS-1:0] m_tdata
);
  // A stalled result beat stays offered with the same payload.
  `MDS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `MDS_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  // The line store clearing pass closes the input on leaving reset.
  `MDS_ASSERT_NEXT_ALWAYS(a_clear_closed, clk, rst, !s_tready)
  // One pixel is worked on at a time.
  `MDS_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
endmodule

bind mitchell_downscale_2x mds_checker #(.DATA_BITS(DATA_BITS)) u_mds_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
